/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros used by the timer table top level; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition must never be true at a clock edge outside reset
`define PTT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define PTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define PTT_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`define PTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/ptt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the periodic timer table.
// ---------------------------------------------------------------------------
package ptt_pkg;

   // request codes
   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_TICK   = 3'd2;
   localparam logic [2:0] REQ_CLEAR  = 3'd3;
   localparam logic [2:0] REQ_QUERY  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // firings reported by one tick at most
   localparam int MAX_RES = 16;
   localparam int CNT_W   = $clog2(MAX_RES + 1);

   // one table entry as held in the entry ram, id in the lowest bits
   typedef struct packed {
      logic signed [16:0] repeats;
      logic [30:0]        period;
      logic [31:0]        due;
      logic [15:0]        id;
   } ptt_entry_type;

   localparam int ENT_W = $bits(ptt_entry_type);

   // latched request word
   typedef struct packed {
      logic [2:0]    kind;
      logic [31:0]   now;
      ptt_entry_type ent;
   } ptt_req_type;

   // one result word handed to the output register
   typedef struct packed {
      logic [2:0]         status;
      logic               fired;
      logic [15:0]        fired_id;
      logic [31:0]        due;
      logic [30:0]        period;
      logic signed [16:0] repeats;
      logic               last;
   } ptt_res_type;

endpackage

/* rtl/core/ptt_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_ram
// Generic single-port-write, single-port-read ram with registered read data.
// ---------------------------------------------------------------------------
module ptt_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port; read data holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ptt_out.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_out
// Result output register; frees the scan engine from the response stall.
// ---------------------------------------------------------------------------
module ptt_out
   import ptt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ptt_res_type res,
   output logic        out_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // fired_id, found_due_time, found_period, found_repeats
   output logic [3:0]  rsp_tuser,  // status, fired
   output logic        rsp_tlast
);

   logic        vld_ff, vld_in;
   ptt_res_type res_ff;

   // register is free when empty or being drained this cycle
   assign out_free = !vld_ff || rsp_tready;

   always_comb begin
      vld_in = vld_ff;
      if (push) begin
         vld_in = 1'b1;
      end else if (rsp_tready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (push) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {res_ff.repeats, res_ff.period, res_ff.due, res_ff.fired_id};
   assign rsp_tuser  = {res_ff.fired, res_ff.status};
   assign rsp_tlast  = res_ff.last;

endmodule

/* rtl/core/ptt_scan.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ptt_scan
// Request sequencer: walks the entry ram one slot a cycle while the process stage is not
// stalled, keeps valid bits, writes back fired entries and builds the result words.
// ---------------------------------------------------------------------------
module ptt_scan
   import ptt_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [127:0]     req_tdata,
   input  logic [2:0]       req_tuser,
   output logic             ram_rd_en,
   output logic [AW-1:0]    ram_rd_addr,
   input  logic [ENT_W-1:0] ram_rd_data,
   output logic             ram_wr_en,
   output logic [AW-1:0]    ram_wr_addr,
   output logic [ENT_W-1:0] ram_wr_data,
   output logic             push,
   output ptt_res_type      res,
   input  logic             out_free
);

   localparam int IW = $clog2(ENTRIES + 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IW-1:0]      iss_ff, iss_in;
   logic               pv_ff, pv_in;
   logic [AW-1:0]      pidx_ff, pidx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic               hit_ff, hit_in;
   logic               free_vld_ff, free_vld_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [15:0]        pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]   fire_cnt_ff, fire_cnt_in;
   ptt_req_type        req_ff, req_in;
   ptt_entry_type      qry_ff, qry_in;

   ptt_entry_type d;
   ptt_entry_type upd;
   logic          slot_v;
   logic          match;
   logic          due_hit;
   logic          fire;
   logic          kill;
   logic          stall;
   logic          step;
   logic [32:0]   due_sum;

   assign req_tready = (state_ff == S_IDLE) && !reset;

   // slot in the process stage
   always_comb begin
      d       = ptt_entry_type'(ram_rd_data);
      slot_v  = valid_ff[pidx_ff];
      match   = slot_v && (d.id == req_ff.ent.id);
      due_hit = slot_v && (req_ff.kind == REQ_TICK) && (d.due <= req_ff.now)
                && (fire_cnt_ff < CNT_W'(MAX_RES));
      fire    = due_hit && (d.repeats != 17'sd0);
      kill    = due_hit && (d.repeats == 17'sd0);
      stall   = (state_ff == S_SCAN) && pv_ff && fire && pend_vld_ff && !out_free;
      step    = (state_ff == S_SCAN) && pv_ff && !stall;
   end

   // fired entry: saturating due advance, finite count decrement
   always_comb begin
      due_sum = {1'b0, d.due} + {2'b00, d.period};
      upd     = d;
      upd.due = due_sum[32] ? 32'hFFFF_FFFF : due_sum[31:0];
      if (d.repeats > 17'sd0) begin
         upd.repeats = d.repeats - 17'sd1;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      iss_in      = iss_ff;
      pv_in       = pv_ff;
      pidx_in     = pidx_ff;
      valid_in    = valid_ff;
      hit_in      = hit_ff;
      free_vld_in = free_vld_ff;
      free_idx_in = free_idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_id_in  = pend_id_ff;
      fire_cnt_in = fire_cnt_ff;
      req_in      = req_ff;
      qry_in      = qry_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = iss_ff[AW-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = pidx_ff;
      ram_wr_data = upd;
      push        = 1'b0;
      res         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               req_in      = '{kind: req_tuser, now: req_tdata[127:96],
                               ent: ptt_entry_type'(req_tdata[95:0])};
               iss_in      = '0;
               pv_in       = 1'b0;
               hit_in      = 1'b0;
               free_vld_in = 1'b0;
               pend_vld_in = 1'b0;
               fire_cnt_in = '0;
               unique case (req_tuser) inside
                  REQ_ADD: begin
                     state_in = (req_tdata[47:16] < req_tdata[127:96]) ? S_FINISH : S_SCAN;
                  end
                  REQ_REMOVE, REQ_TICK, REQ_QUERY: begin
                     state_in = S_SCAN;
                  end
                  REQ_CLEAR: begin
                     valid_in = '0;
                     state_in = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue the next slot read unless the process stage is stalled
            if ((iss_ff < IW'(ENTRIES)) && !stall) begin
               ram_rd_en = 1'b1;
               iss_in    = iss_ff + 1'b1;
               pidx_in   = iss_ff[AW-1:0];
            end
            pv_in = stall ? 1'b1 : ram_rd_en;

            if (step) begin
               // id search for add, remove and query
               if (match) begin
                  hit_in = 1'b1;
                  if (!hit_ff) begin
                     qry_in = d;
                     if (req_ff.kind == REQ_REMOVE) begin
                        valid_in[pidx_ff] = 1'b0;
                     end
                  end
               end
               // lowest free slot for add
               if (!slot_v && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = pidx_ff;
               end
               // exhausted entry is dropped without firing
               if (kill) begin
                  valid_in[pidx_ff] = 1'b0;
               end
               // firing: write back and hold the id until the next one is known
               if (fire) begin
                  ram_wr_en = 1'b1;
                  if (pend_vld_ff) begin
                     push         = 1'b1;
                     res.status   = ST_OK;
                     res.fired    = 1'b1;
                     res.fired_id = pend_id_ff;
                  end
                  pend_vld_in = 1'b1;
                  pend_id_in  = d.id;
                  fire_cnt_in = fire_cnt_ff + 1'b1;
               end
            end

            if ((iss_ff == IW'(ENTRIES)) && !pv_ff) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (out_free) begin
               push     = 1'b1;
               res.last = 1'b1;
               state_in = S_IDLE;
               unique case (req_ff.kind) inside
                  REQ_ADD: begin
                     if (req_ff.ent.due < req_ff.now) begin
                        res.status = ST_EXPIRED;
                     end else if (hit_ff) begin
                        res.status = ST_EXISTS;
                     end else if (!free_vld_ff) begin
                        res.status = ST_FULL;
                     end else begin
                        res.status            = ST_OK;
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = free_idx_ff;
                        ram_wr_data           = req_ff.ent;
                        valid_in[free_idx_ff] = 1'b1;
                     end
                  end
                  REQ_REMOVE: begin
                     res.status = hit_ff ? ST_OK : ST_NOT_FOUND;
                  end
                  REQ_QUERY: begin
                     if (hit_ff) begin
                        res.status  = ST_OK;
                        res.due     = qry_ff.due;
                        res.period  = qry_ff.period;
                        res.repeats = qry_ff.repeats;
                     end else begin
                        res.status = ST_NOT_FOUND;
                     end
                  end
                  REQ_TICK: begin
                     res.status   = ST_OK;
                     res.fired    = pend_vld_ff;
                     res.fired_id = pend_vld_ff ? pend_id_ff : 16'd0;
                  end
                  default: begin
                     res.status = ST_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         iss_ff      <= '0;
         pv_ff       <= 1'b0;
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         free_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         iss_ff      <= iss_in;
         pv_ff       <= pv_in;
         valid_ff    <= valid_in;
         hit_ff      <= hit_in;
         free_vld_ff <= free_vld_in;
         pend_vld_ff <= pend_vld_in;
         fire_cnt_ff <= fire_cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pidx_ff     <= pidx_in;
      free_idx_ff <= free_idx_in;
      pend_id_ff  <= pend_id_in;
      req_ff      <= req_in;
      qry_ff      <= qry_in;
   end

endmodule

/* rtl/core/periodic_timer_table.sv */
`timescale 1ns / 1ps
// Add, remove, query and tick scan the entry ram one slot per cycle, unless a stalled
// response holds the scan; clear-all, unused codes and an add with an expired due time
// skip the scan. A new request is accepted only once the last result word of the previous
// one has been pushed to the response register; a stalled response delays that push.
// Reset: synchronous, clears all slot valid bits and the sequencer; ram contents are kept
// but unreachable, so no clearing pass is needed.
// ---------------------------------------------------------------------------
// periodic_timer_table
// Table of periodic timed actions with add, remove, query, clear and tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_timer_table
   import ptt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // timer_id, due_time, period, repeat_count, now_time
   input  logic [2:0]   req_tuser,  // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // fired_id, found_due_time, found_period, found_repeats
   output logic [3:0]   rsp_tuser,  // status, fired
   output logic         rsp_tlast
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [ENT_W-1:0] ram_rd_data;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [ENT_W-1:0] ram_wr_data;
   logic             push;
   logic             out_free;
   ptt_res_type      res;
   logic             push_full;
   logic             ram_clash;
   logic             req_taken;

   // entry storage
   ptt_ram #(
      .WIDTH(ENT_W),
      .DEPTH(ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // request sequencer and slot scan
   ptt_scan #(
      .ENTRIES(ENTRIES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ram_rd_en  (ram_rd_en),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .push       (push),
      .res        (res),
      .out_free   (out_free)
   );

   // response register
   ptt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .res       (res),
      .out_free  (out_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // checks
   assign push_full = push && !out_free;
   assign ram_clash = ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr);
   assign req_taken = req_tvalid && req_tready;

   `PTT_ASSERT_NEVER(a_push_when_full, clock, reset, push_full, "result pushed into a full register")
   `PTT_ASSERT_NEVER(a_ram_same_slot, clock, reset, ram_clash, "ram read and write hit one slot")
   `PTT_ASSERT_NEXT(a_one_request, clock, reset, req_taken, !req_tready, "request taken while busy")

endmodule

/* tb/tb_periodic_timer_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_periodic_timer_table
// Self-checking bench for the periodic timer table. A shadow copy of the
// sixteen slots predicts every response word: add status, remove and query
// lookups, clear-all, tick firings in slot order with repeat-count handling
// and due-time saturation. Directed corner cases run first, then random
// traffic under several idle and stall mixes, then a long response hold-off
// that backs the table up into its request port.
// ---------------------------------------------------------------------------
module tb_periodic_timer_table
   import ptt_pkg::*;
();

   localparam int          TABLE_DEPTH   = 16;
   localparam int          SETTLE_CYCLES = 40;
   localparam int          LIMIT_NS      = 5_000_000;
   localparam logic [2:0]  REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0]  REQ_SPARE_HI  = 3'd7;
   localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
   localparam logic [30:0] PERIOD_MAX    = 31'h7FFF_FFFF;
   localparam logic signed [16:0] REP_FOREVER = -17'sd1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;  // timer_id, due_time, period, repeat_count, now_time
   logic [2:0]   req_tuser = '0;  // req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;       // fired_id, found_due_time, found_period, found_repeats
   logic [3:0]   rsp_tuser;       // status, fired
   logic         rsp_tlast;

   // shadow of the timer slots
   logic              shadow_valid   [TABLE_DEPTH];
   logic [15:0]       shadow_id      [TABLE_DEPTH];
   logic [31:0]       shadow_due     [TABLE_DEPTH];
   logic [30:0]       shadow_period  [TABLE_DEPTH];
   logic signed [16:0] shadow_repeats [TABLE_DEPTH];

   ptt_res_type awaited_words[$];
   int          err_count  = 0;
   int          idle_pct   = 0;
   int          stall_pct  = 0;
   int          hold_left  = 0;
   logic [31:0] sim_now    = '0;

   periodic_timer_table #(
      .ENTRIES(TABLE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #(LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? TIME_MAX : sum[31:0];
   endfunction

   function automatic int find_slot(input logic [15:0] id);
      for (int i = 0; i < TABLE_DEPTH; i++)
         if (shadow_valid[i] && shadow_id[i] == id) return i;
      return -1;
   endfunction

   task automatic push_word(input logic [2:0] st, input logic fired, input logic [15:0] fid,
                            input logic [31:0] due, input logic [30:0] per,
                            input logic signed [16:0] rep, input logic last);
      ptt_res_type w;
      w.status   = st;
      w.fired    = fired;
      w.fired_id = fid;
      w.due      = due;
      w.period   = per;
      w.repeats  = rep;
      w.last     = last;
      awaited_words.insert(awaited_words.size(), w);
   endtask

   // apply one accepted request to the shadow table and queue its words
   task automatic table_apply(input ptt_req_type r);
      int          slot;
      logic [2:0]  st;
      logic [15:0] fire_ids[$];
      st = ST_OK;
      case (r.kind)
         REQ_ADD: begin
            slot = -1;
            if (r.ent.due < r.now) begin
               st = ST_EXPIRED;
            end else if (find_slot(r.ent.id) >= 0) begin
               st = ST_EXISTS;
            end else begin
               for (int i = 0; i < TABLE_DEPTH; i++)
                  if (!shadow_valid[i] && slot < 0) slot = i;
               if (slot < 0) begin
                  st = ST_FULL;
               end else begin
                  shadow_valid[slot]   = 1'b1;
                  shadow_id[slot]      = r.ent.id;
                  shadow_due[slot]     = r.ent.due;
                  shadow_period[slot]  = r.ent.period;
                  shadow_repeats[slot] = r.ent.repeats;
               end
            end
            push_word(st, 1'b0, '0, '0, '0, '0, 1'b1);
         end
         REQ_REMOVE: begin
            slot = find_slot(r.ent.id);
            if (slot >= 0) shadow_valid[slot] = 1'b0;
            push_word(slot >= 0 ? ST_OK : ST_NOT_FOUND, 1'b0, '0, '0, '0, '0, 1'b1);
         end
         REQ_TICK: begin
            // scan slots in order, firing due ones and dropping spent ones
            for (int i = 0; i < TABLE_DEPTH && fire_ids.size() < MAX_RES; i++) begin
               if (shadow_valid[i] && shadow_due[i] <= r.now) begin
                  if (shadow_repeats[i] == 0) begin
                     shadow_valid[i] = 1'b0;
                  end else begin
                     if (shadow_repeats[i] > 0) shadow_repeats[i] = shadow_repeats[i] - 1;
                     shadow_due[i] = sat_add(shadow_due[i], {1'b0, shadow_period[i]});
                     fire_ids.insert(fire_ids.size(), shadow_id[i]);
                  end
               end
            end
            if (fire_ids.size() == 0)
               push_word(ST_OK, 1'b0, '0, '0, '0, '0, 1'b1);
            foreach (fire_ids[k])
               push_word(ST_OK, 1'b1, fire_ids[k], '0, '0, '0, k == fire_ids.size() - 1);
         end
         REQ_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
            push_word(ST_OK, 1'b0, '0, '0, '0, '0, 1'b1);
         end
         REQ_QUERY: begin
            slot = find_slot(r.ent.id);
            if (slot >= 0)
               push_word(ST_OK, 1'b0, '0, shadow_due[slot], shadow_period[slot],
                         shadow_repeats[slot], 1'b1);
            else
               push_word(ST_NOT_FOUND, 1'b0, '0, '0, '0, '0, 1'b1);
         end
         default: begin
            push_word(ST_OK, 1'b0, '0, '0, '0, '0, 1'b1);
         end
      endcase
   endtask

   function automatic ptt_req_type make_req(input logic [2:0] kind, input logic [15:0] id,
                                            input logic [31:0] due, input logic [30:0] per,
                                            input logic signed [16:0] rep,
                                            input logic [31:0] now);
      ptt_req_type r;
      r.kind        = kind;
      r.now         = now;
      r.ent.id      = id;
      r.ent.due     = due;
      r.ent.period  = per;
      r.ent.repeats = rep;
      return r;
   endfunction

   // offer one request word, idling first at random, predict on accept
   task automatic send_word(input ptt_req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {r.now, r.ent};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_apply(r);
   endtask

   // drop valid and wait until every queued word has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random request, mostly well-formed around a rising current time
   function automatic ptt_req_type next_req();
      ptt_req_type r;
      int          sel;
      sel = $urandom_range(99);
      r.kind        = REQ_QUERY;
      r.now         = sim_now;
      r.ent.id      = ($urandom_range(99) < 85) ? 16'($urandom_range(23)) : 16'($urandom);
      r.ent.due     = $urandom;
      r.ent.period  = 31'($urandom);
      r.ent.repeats = 17'($urandom_range(65535));
      if (sel < 36) begin
         r.kind = REQ_ADD;
         case ($urandom_range(9))
            0: begin
               r.ent.due = sim_now;
               r.now     = sat_add(sim_now, $urandom_range(1, 9));
            end
            1: r.ent.due = $urandom;
            default: r.ent.due = sat_add(sim_now, $urandom_range(0, 40));
         endcase
         sel = $urandom_range(99);
         if (sel < 10)      r.ent.period = '0;
         else if (sel < 80) r.ent.period = 31'($urandom_range(1, 12));
         sel = $urandom_range(99);
         if (sel < 30)      r.ent.repeats = REP_FOREVER;
         else if (sel < 45) r.ent.repeats = '0;
         else if (sel < 85) r.ent.repeats = 17'($urandom_range(1, 4));
      end else if (sel < 62) begin
         r.kind  = REQ_TICK;
         sim_now = sat_add(sim_now, $urandom_range(0, 15));
         r.now   = sim_now;
      end else if (sel < 74) begin
         r.kind = REQ_REMOVE;
      end else if (sel < 88) begin
         r.kind = REQ_QUERY;
      end else if (sel < 93) begin
         r.kind = REQ_CLEAR;
      end else if (sel < 96) begin
         r.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      end else begin
         // noise: any code, any time
         r.kind = 3'($urandom_range(7));
         r.now  = $urandom;
      end
      return r;
   endfunction

   // corner cases: empty table, all statuses, full table, saturation, spent counts
   task automatic test_directed_cases();
      idle_pct  = 0;
      stall_pct = 0;
      send_word(make_req(REQ_TICK, '0, '0, '0, '0, '0));
      send_word(make_req(REQ_QUERY, 16'hFFFF, '0, '0, '0, '0));
      send_word(make_req(REQ_REMOVE, 16'hFFFF, '0, '0, '0, '0));
      send_word(make_req(REQ_ADD, 16'hFFFF, 32'd99, 31'd1, 17'sd1, 32'd100));
      // fill every slot; due equal to now is still accepted
      send_word(make_req(REQ_ADD, 16'h0000, 32'd100, PERIOD_MAX, REP_FOREVER, 32'd100));
      send_word(make_req(REQ_ADD, 16'hFFFF, TIME_MAX, 31'd5, REP_FOREVER, 32'd0));
      send_word(make_req(REQ_ADD, 16'h0102, 32'd150, 31'd10, 17'sd1, 32'd100));
      for (int i = 3; i < TABLE_DEPTH; i++)
         send_word(make_req(REQ_ADD, 16'h0100 + 16'(i), 32'd10 + 32'(i), 31'd1,
                            17'sd65535, 32'd0));
      // duplicate id wins over a full table
      send_word(make_req(REQ_ADD, 16'h0000, 32'd500, 31'd1, 17'sd1, 32'd0));
      send_word(make_req(REQ_ADD, 16'h1234, 32'd500, 31'd1, 17'sd1, 32'd0));
      // every slot fires, then the spent one is dropped without firing
      send_word(make_req(REQ_TICK, '0, '0, '0, '0, TIME_MAX));
      send_word(make_req(REQ_TICK, '0, '0, '0, '0, TIME_MAX));
      send_word(make_req(REQ_QUERY, 16'h0000, '0, '0, '0, '0));
      send_word(make_req(REQ_QUERY, 16'h0102, '0, '0, '0, '0));
      send_word(make_req(REQ_REMOVE, 16'h0103, '0, '0, '0, '0));
      send_word(make_req(REQ_SPARE_LO, 16'hFFFF, TIME_MAX, PERIOD_MAX, REP_FOREVER, TIME_MAX));
      send_word(make_req(REQ_SPARE_HI, '0, '0, '0, '0, '0));
      send_word(make_req(REQ_CLEAR, '0, '0, '0, '0, '0));
      settle();
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int count,
                                      input logic [31:0] base_now);
      idle_pct  = idle;
      stall_pct = stall;
      sim_now   = base_now;
      for (int n = 0; n < count; n++) send_word(next_req());
      settle();
   endtask

   // response side held off while requests keep coming
   task automatic test_output_stall();
      idle_pct  = 0;
      stall_pct = 0;
      sim_now   = 32'd1000;
      for (int i = 0; i < 6; i++)
         send_word(make_req(REQ_ADD, 16'h0200 + 16'(i), 32'd1000, 31'd1, REP_FOREVER, 32'd0));
      hold_left = 600;
      for (int n = 0; n < 30; n++) send_word(next_req());
      settle();
   endtask

   // response ready, with long hold-off when requested
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         err_count++;
         if (err_count <= 10)
            $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
      end
   endtask

   // compare each response word with the oldest awaited one
   always @(posedge clock) begin : rsp_checker
      ptt_res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected word: tuser %h tdata %h at %0t",
                        rsp_tuser, rsp_tdata, $realtime);
         end else begin
            want = awaited_words.pop_front();
            check_field("status",   32'(want.status),   32'(rsp_tuser[2:0]));
            check_field("fired",    32'(want.fired),    32'(rsp_tuser[3]));
            check_field("fired_id", 32'(want.fired_id), 32'(rsp_tdata[15:0]));
            check_field("due",      want.due,           rsp_tdata[47:16]);
            check_field("period",   32'(want.period),   32'(rsp_tdata[78:48]));
            check_field("repeats",  32'(unsigned'(want.repeats)), 32'(rsp_tdata[95:79]));
            check_field("last",     32'(want.last),     32'(rsp_tlast));
         end
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic(0, 0, 64, 32'($urandom_range(1000)));
      test_random_traffic(77, 0, 64, 32'($urandom));
      test_random_traffic(0, 77, 64, 32'hFFFF_FE00);
      test_random_traffic(23, 23, 64, 32'($urandom_range(1000)));
      test_output_stall();
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
